// ===== hw/rtl/ddo_pkg.sv =====
// shared types, constants and the arctangent table for the odometry block
package ddo_pkg;

  localparam int TickW    = 16;
  localparam int DistW    = 16;
  localparam int AngW     = 32;
  localparam int PosW     = 48;
  localparam int IdxW     = 5;   // 32-entry arctangent table
  localparam int CordW    = 34;  // cordic x, y and z width
  localparam int AtanW    = 30;
  localparam int ProdOpW  = 18;  // half of a cordic result plus sign
  localparam int SumW     = 34;  // (dl + dr) * distance_per_tick
  localparam int DiffW    = 50;  // (dr - dl) * angle_per_tick_diff
  localparam int AccW     = 68;  // position product accumulator
  localparam int RoundPos = 30;
  localparam int ShiftPos = 31;

  localparam logic signed [CordW-1:0] CordicGain = 34'sd652032874;
  localparam logic [IdxW-1:0]         ProdLast   = 5'd3;

  typedef struct packed {
    logic            cap;   // capture input request
    logic            mul;   // travel and heading products
    logic            init;  // load cordic start vector
    logic            iter;  // one cordic rotation
    logic            fix;   // undo half-turn fold
    logic            prod;  // one partial product of the position step
    logic            upd;   // commit pose
    logic [IdxW-1:0] step;
  } cmd_t;

  function automatic logic [AtanW-1:0] atan_entry(input logic [IdxW-1:0] idx);
    logic [AtanW-1:0] v;
    case (idx)
      5'd0:  v = 30'd536870912;
      5'd1:  v = 30'd316933406;
      5'd2:  v = 30'd167458907;
      5'd3:  v = 30'd85004756;
      5'd4:  v = 30'd42667331;
      5'd5:  v = 30'd21354465;
      5'd6:  v = 30'd10679838;
      5'd7:  v = 30'd5340245;
      5'd8:  v = 30'd2670163;
      5'd9:  v = 30'd1335087;
      5'd10: v = 30'd667544;
      5'd11: v = 30'd333772;
      5'd12: v = 30'd166886;
      5'd13: v = 30'd83443;
      5'd14: v = 30'd41722;
      5'd15: v = 30'd20861;
      5'd16: v = 30'd10430;
      5'd17: v = 30'd5215;
      5'd18: v = 30'd2608;
      5'd19: v = 30'd1304;
      5'd20: v = 30'd652;
      5'd21: v = 30'd326;
      5'd22: v = 30'd163;
      5'd23: v = 30'd81;
      5'd24: v = 30'd41;
      5'd25: v = 30'd20;
      5'd26: v = 30'd10;
      5'd27: v = 30'd5;
      5'd28: v = 30'd3;
      5'd29: v = 30'd1;
      5'd30: v = 30'd1;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== hw/rtl/ddo_datapath.sv =====
// odometry datapath: products, shared cordic stage, position mac and pose registers
module ddo_datapath (
  input  logic                        clk,
  input  logic                        rst_n,
  input  ddo_pkg::cmd_t               cmd,
  input  logic [ddo_pkg::TickW-1:0]   dticks_left,
  input  logic [ddo_pkg::TickW-1:0]   dticks_right,
  input  logic [ddo_pkg::DistW-1:0]   distance_per_tick,
  input  logic [ddo_pkg::AngW-1:0]    angle_per_tick_diff,
  output logic [ddo_pkg::PosW-1:0]    pos_x,
  output logic [ddo_pkg::PosW-1:0]    pos_y,
  output logic [ddo_pkg::AngW-1:0]    heading
);

  localparam int CW = ddo_pkg::CordW;
  localparam int AW = ddo_pkg::AccW;
  localparam int PW = ddo_pkg::PosW;
  localparam int DxW = AW - ddo_pkg::ShiftPos;

  logic signed [ddo_pkg::TickW-1:0]   dl_r, dr_r;
  logic signed [ddo_pkg::SumW-1:0]    s_r, s_nxt;
  logic signed [ddo_pkg::DiffW-1:0]   d_r, d_nxt;
  logic signed [CW-1:0]               x_r, x_nxt, y_r, y_nxt, z_r, z_nxt;
  logic                               flip_r, flip_nxt;
  logic signed [AW-1:0]               accx_r, accx_nxt, accy_r, accy_nxt;
  logic signed [PW-1:0]               posx_r, posx_nxt, posy_r, posy_nxt;
  logic [ddo_pkg::AngW-1:0]           head_r, head_nxt;

  logic signed [ddo_pkg::TickW:0]     tsum, tdiff;
  logic [ddo_pkg::AngW-1:0]           ang, rot;
  logic signed [CW-1:0]               xs, ys, at, cval;
  logic signed [ddo_pkg::ProdOpW-1:0] opnd;
  logic signed [ddo_pkg::SumW+ddo_pkg::ProdOpW-1:0] pp;
  logic signed [AW-1:0]               pp_lo, pp_hi, acc_sel, acc_new;
  logic signed [DxW-1:0]              dx, dy;
  logic signed [PW:0]                 sumx, sumy;

  function automatic logic signed [PW-1:0] sat_pos(input logic signed [PW:0] v);
    logic signed [PW-1:0] r;
    if (v[PW] == v[PW-1]) begin
      r = v[PW-1:0];
    end else if (v[PW]) begin
      r = {1'b1, {(PW-1){1'b0}}};
    end else begin
      r = {1'b0, {(PW-1){1'b1}}};
    end
    return r;
  endfunction

  always_comb begin
    tsum  = {dl_r[ddo_pkg::TickW-1], dl_r} + {dr_r[ddo_pkg::TickW-1], dr_r};
    tdiff = {dr_r[ddo_pkg::TickW-1], dr_r} - {dl_r[ddo_pkg::TickW-1], dl_r};
    s_nxt = tsum * $signed({1'b0, distance_per_tick});
    d_nxt = tdiff * $signed({1'b0, angle_per_tick_diff});

    // midpoint heading, folded into the right half plane
    ang      = head_r + d_r[ddo_pkg::AngW+16:17];
    flip_nxt = ang[31] ^ ang[30];
    rot      = {ang[30], ang[30:0]};

    xs = x_r >>> cmd.step;
    ys = y_r >>> cmd.step;
    at = $signed({{(CW-ddo_pkg::AtanW){1'b0}}, ddo_pkg::atan_entry(cmd.step)});

    // one partial product per cycle: low half then high half of cos, then of sin
    cval  = cmd.step[1] ? y_r : x_r;
    opnd  = cmd.step[0] ? cval[CW-1:16] : $signed({2'b00, cval[15:0]});
    pp    = s_r * opnd;
    pp_lo = {{(AW-$bits(pp)){pp[$bits(pp)-1]}}, pp};
    pp_hi = {pp, 16'b0};
    acc_sel = cmd.step[1] ? accy_r : accx_r;
    if (cmd.step[0]) begin
      acc_new = acc_sel + pp_hi;
    end else begin
      acc_new = pp_lo + (AW'(1) <<< ddo_pkg::RoundPos);
    end

    dx   = accx_r[AW-1:ddo_pkg::ShiftPos];
    dy   = accy_r[AW-1:ddo_pkg::ShiftPos];
    sumx = {posx_r[PW-1], posx_r} + {{(PW+1-DxW){dx[DxW-1]}}, dx};
    sumy = {posy_r[PW-1], posy_r} + {{(PW+1-DxW){dy[DxW-1]}}, dy};

    x_nxt = x_r;
    y_nxt = y_r;
    z_nxt = z_r;
    if (cmd.init) begin
      x_nxt = ddo_pkg::CordicGain;
      y_nxt = '0;
      z_nxt = {{(CW-32){rot[31]}}, rot};
    end else if (cmd.iter) begin
      if (!z_r[CW-1]) begin
        x_nxt = x_r - ys;
        y_nxt = y_r + xs;
        z_nxt = z_r - at;
      end else begin
        x_nxt = x_r + ys;
        y_nxt = y_r - xs;
        z_nxt = z_r + at;
      end
    end else if (cmd.fix && flip_r) begin
      x_nxt = -x_r;
      y_nxt = -y_r;
    end

    accx_nxt = accx_r;
    accy_nxt = accy_r;
    if (cmd.prod) begin
      if (cmd.step[1]) begin
        accy_nxt = acc_new;
      end else begin
        accx_nxt = acc_new;
      end
    end

    posx_nxt = posx_r;
    posy_nxt = posy_r;
    head_nxt = head_r;
    if (cmd.upd) begin
      posx_nxt = sat_pos(sumx);
      posy_nxt = sat_pos(sumy);
      head_nxt = head_r + d_r[ddo_pkg::AngW+15:16];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      dl_r <= dticks_left;
      dr_r <= dticks_right;
    end
    if (cmd.mul) begin
      s_r <= s_nxt;
      d_r <= d_nxt;
    end
    if (cmd.init) begin
      flip_r <= flip_nxt;
    end
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    z_r    <= z_nxt;
    accx_r <= accx_nxt;
    accy_r <= accy_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      posx_r <= '0;
      posy_r <= '0;
      head_r <= '0;
    end else begin
      posx_r <= posx_nxt;
      posy_r <= posy_nxt;
      head_r <= head_nxt;
    end
  end

  assign pos_x   = posx_r;
  assign pos_y   = posy_r;
  assign heading = head_r;

endmodule

// ===== hw/rtl/ddo_ctrl.sv =====
// odometry sequencer: steps one request through multiply, cordic, mac and update
module ddo_ctrl #(
  parameter int CORDIC_STEPS = 24
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  output logic          out_tvalid,
  input  logic          out_tready,
  output ddo_pkg::cmd_t cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_INIT = 3'd2;
  localparam logic [2:0] S_ITER = 3'd3;
  localparam logic [2:0] S_FIX  = 3'd4;
  localparam logic [2:0] S_PROD = 3'd5;
  localparam logic [2:0] S_UPD  = 3'd6;

  localparam int Steps = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
  localparam logic [ddo_pkg::IdxW-1:0] IterLast = ddo_pkg::IdxW'(Steps - 1);

  logic [2:0]                state_r, state_nxt;
  logic [ddo_pkg::IdxW-1:0]  cnt_r, cnt_nxt;
  logic                      ovalid_r, ovalid_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    cmd.step  = cnt_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.cap   = 1'b1;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_INIT;
      end
      S_INIT: begin
        cmd.init  = 1'b1;
        cnt_nxt   = '0;
        state_nxt = S_ITER;
      end
      S_ITER: begin
        cmd.iter = 1'b1;
        if (cnt_r == IterLast) begin
          state_nxt = S_FIX;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_FIX: begin
        cmd.fix   = 1'b1;
        cnt_nxt   = '0;
        state_nxt = S_PROD;
      end
      S_PROD: begin
        cmd.prod = 1'b1;
        if (cnt_r == ddo_pkg::ProdLast) begin
          state_nxt = S_UPD;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_UPD: begin
        if (!ovalid_r || out_tready) begin
          cmd.upd   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cmd.upd) begin
      ovalid_nxt = 1'b1;
    end else if (out_tready) begin
      ovalid_nxt = 1'b0;
    end else begin
      ovalid_nxt = ovalid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cnt_r    <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = ovalid_r;

endmodule

// ===== hw/rtl/differential_drive_odometry.sv =====
// differential-drive wheel odometry top level: register port, sequencer and datapath
// Each request carries the signed left and right encoder tick changes of one control
// period and yields one pose: x and y in 2^-24 metre units (saturating 48-bit two's
// complement) and heading as a 32-bit binary angle that wraps once per turn. Travel
// uses distance_per_tick (register 0, byte address 0) and the heading change uses
// angle_per_tick_diff (register 1, byte address 4); both reset to zero and should be
// written only while the block is idle. Position advances along the midpoint heading
// through a CORDIC sine/cosine. Each request passes in order through the accept, the
// travel and heading products, the CORDIC load, the CORDIC iterations on the single
// shared rotation stage, undoing the half-turn fold, four partial products on the
// shared 34x18 multiplier for the position, and the pose commit, which waits until
// any earlier result has been taken. Requests are handled one at a
// time; a new request is taken while the previous result still waits on the output.
module differential_drive_odometry #(
  parameter int CORDIC_STEPS = 24
) (
  input  logic         clk,
  input  logic         rst_n,
  // input requests
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [31:0]  in_tdata,   // [15:0] dticks_left, [31:16] dticks_right
  // pose results
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata,  // [47:0] pos_x, [95:48] pos_y, [127:96] heading
  // register port
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [2:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  localparam logic REG_DIST = 1'b0;
  localparam logic REG_ANG  = 1'b1;

  logic [ddo_pkg::DistW-1:0] dist_r;
  logic [ddo_pkg::AngW-1:0]  ang_r;
  logic                      cfg_wr;
  ddo_pkg::cmd_t             cmd;
  logic [ddo_pkg::PosW-1:0]  pos_x, pos_y;
  logic [ddo_pkg::AngW-1:0]  heading;

  // register file: write on the access cycle, register index from address bit 2
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dist_r <= '0;
      ang_r  <= '0;
    end else if (cfg_wr) begin
      case (cfg_paddr[2])
        REG_DIST: dist_r <= cfg_pwdata[ddo_pkg::DistW-1:0];
        REG_ANG:  ang_r  <= cfg_pwdata;
        default:  ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      REG_DIST: cfg_prdata = {{(32-ddo_pkg::DistW){1'b0}}, dist_r};
      REG_ANG:  cfg_prdata = ang_r;
      default:  cfg_prdata = '0;
    endcase
  end

  // sequencer
  ddo_ctrl #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  // arithmetic and pose state; the pose registers double as the output register
  ddo_datapath u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .dticks_left         (in_tdata[15:0]),
    .dticks_right        (in_tdata[31:16]),
    .distance_per_tick   (dist_r),
    .angle_per_tick_diff (ang_r),
    .pos_x               (pos_x),
    .pos_y               (pos_y),
    .heading             (heading)
  );

  assign out_tdata = {heading, pos_y, pos_x};

  // pose only moves on a commit
  a_pose_on_commit: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(out_tdata) |-> $past(cmd.upd))
    else $error("pose changed without a commit");

  // one request at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("second request accepted while one is in work");

  // a result appears only after a commit
  a_valid_after_commit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(cmd.upd))
    else $error("result raised without a commit");

  // a commit never overwrites a result that was not taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.upd |-> (!out_tvalid || out_tready))
    else $error("commit over a pending result");

endmodule
